// ===== design/pla_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and lane helpers for the packed lane ALU.
// Used by every module of the block; depends on nothing else.
package pla_pkg;

    localparam int WORD_BITS = 64;
    localparam int WORD_BYTES = WORD_BITS / 8;
    localparam int PROD_COUNT = WORD_BYTES * WORD_BYTES;
    localparam int ROW_COUNT = 2 * WORD_BYTES;
    localparam int PART_COUNT = ROW_COUNT / 4;

    // Operation codes.
    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_OR  = 3'd1;
    localparam logic [2:0] OP_XOR = 3'd2;
    localparam logic [2:0] OP_ADD = 3'd3;
    localparam logic [2:0] OP_SUB = 3'd4;
    localparam logic [2:0] OP_MUL = 3'd5;
    localparam logic [2:0] OP_NOT = 3'd6;
    localparam logic [2:0] OP_NEG = 3'd7;

    // Scalar side codes.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OP_CODE      = 2'd0;
    localparam logic [1:0] CFG_LANE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_SCALAR_SIDE  = 2'd2;
    localparam logic [1:0] CFG_SCALAR_VALUE = 2'd3;

    // Lane width limits for arithmetic, as log2 of the lane width.
    localparam logic [2:0] LW_MIN = 3'd3;
    localparam logic [2:0] LW_MAX = 3'd6;
    localparam logic [2:0] LW_RESET = 3'd3;

    typedef struct packed {
        logic [2:0]           op;
        logic [2:0]           lw;
        logic [1:0]           side;
        logic [WORD_BITS-1:0] scalar;
    } t_cfg;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] lw;
        logic       err;
    } t_ctl;

    // Byte products, entry j*8+i holds left byte i times right byte j.
    typedef logic [PROD_COUNT-1:0][15:0] t_prod;

    // Mask of the bit position within a lane; lane setting seven counts as 64 bits.
    function automatic logic [5:0] lane_mask6(input logic [2:0] lw);
        if (lw >= 3'd6) begin
            return 6'h3F;
        end
        return 6'((7'd1 << lw) - 7'd1);
    endfunction

    // One set bit at the top of each lane.
    function automatic logic [WORD_BITS-1:0] hi_mask(input logic [2:0] lw);
        logic [WORD_BITS-1:0] h;
        logic [5:0]           m;
        m = lane_mask6(lw);
        for (int k = 0; k < WORD_BITS; k++) begin
            h[k] = ((6'(k) & m) == m);
        end
        return h;
    endfunction

endpackage

// ===== design/packed_lane_alu_top.sv =====
`timescale 1ns / 1ps
// Top level of the packed lane ALU: configuration port, four-stage pipeline and
// stream ports. Depends on pla_pkg, pla_cfg, pla_operand, pla_compute, pla_reduce.
//
// The block takes one pair of 64-bit words per cycle while o_s_tready is high and
// returns one result word per item, in order. A result is offered on the output from
// the last of four register stages: operand selection, the lane add and subtract
// together with the byte product array, a first lane-segmented sum of the product
// rows, and the final sum and select into the output register. Every stage has its
// own valid bit and takes a new item as soon as its own content moves on, so bubbles
// collapse and the input keeps being accepted while a finished result waits at the
// output, until the three stages ahead of the output register are full.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data
// and must only change while the pipeline is empty. Arithmetic ops with a lane
// setting below 8 bits or the lane setting seven give a zero result word with the
// width error flag set.
module packed_lane_alu_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    // Input stream.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,   // [63:0] left_word, [127:64] right_word
    // Output stream.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [63:0]   o_m_tdata,   // [63:0] result_word
    output logic          o_m_tuser    // [0] width_error
);

    pla_pkg::t_cfg                 cfg;
    logic                          s1_valid;
    logic                          s1_ready;
    logic [pla_pkg::WORD_BITS-1:0] s1_a;
    logic [pla_pkg::WORD_BITS-1:0] s1_b;
    pla_pkg::t_ctl                 s1_ctl;
    logic                          s2_valid;
    logic                          s2_ready;
    logic [pla_pkg::WORD_BITS-1:0] s2_simple;
    pla_pkg::t_prod                s2_prod;
    pla_pkg::t_ctl                 s2_ctl;

    // Configuration registers.
    pla_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Operand selection stage.
    pla_operand u_operand (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_left     (i_s_tdata[63:0]),
        .i_right    (i_s_tdata[127:64]),
        .i_cfg      (cfg),
        .i_ready_dn (s1_ready),
        .o_valid    (s1_valid),
        .o_a        (s1_a),
        .o_b        (s1_b),
        .o_ctl      (s1_ctl)
    );

    // Lane arithmetic and byte products.
    pla_compute u_compute (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .o_ready    (s1_ready),
        .i_a        (s1_a),
        .i_b        (s1_b),
        .i_ctl      (s1_ctl),
        .i_ready_dn (s2_ready),
        .o_valid    (s2_valid),
        .o_simple   (s2_simple),
        .o_prod     (s2_prod),
        .o_ctl      (s2_ctl)
    );

    // Product reduction and output register.
    pla_reduce u_reduce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_simple   (s2_simple),
        .i_prod     (s2_prod),
        .i_ctl      (s2_ctl),
        .i_ready_dn (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_result   (o_m_tdata),
        .o_err      (o_m_tuser)
    );

endmodule

// ===== design/pla_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers of the packed lane ALU, written through a plain write port.
// Depends on pla_pkg for the register indexes and the configuration struct.
module pla_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_cfg_data,
    output pla_pkg::t_cfg                  o_cfg
);

    pla_pkg::t_cfg r_cfg;

    // Register writes; each register keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op     <= pla_pkg::OP_AND;
            r_cfg.lw     <= pla_pkg::LW_RESET;
            r_cfg.side   <= pla_pkg::SIDE_NONE;
            r_cfg.scalar <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pla_pkg::CFG_OP_CODE:      r_cfg.op     <= i_cfg_data[2:0];
                pla_pkg::CFG_LANE_WIDTH:   r_cfg.lw     <= i_cfg_data[2:0];
                pla_pkg::CFG_SCALAR_SIDE:  r_cfg.side   <= i_cfg_data[1:0];
                pla_pkg::CFG_SCALAR_VALUE: r_cfg.scalar <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/pla_operand.sv =====
`timescale 1ns / 1ps
// First pipeline stage: operand selection with scalar replication and error decode.
// Depends on pla_pkg for codes, types and the lane mask helper.
module pla_operand (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_left,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_right,
    input  pla_pkg::t_cfg                  i_cfg,
    input  logic                           i_ready_dn,
    output logic                           o_valid,
    output logic [pla_pkg::WORD_BITS-1:0]  o_a,
    output logic [pla_pkg::WORD_BITS-1:0]  o_b,
    output pla_pkg::t_ctl                  o_ctl
);

    logic                          r_valid;
    logic [pla_pkg::WORD_BITS-1:0] r_a;
    logic [pla_pkg::WORD_BITS-1:0] r_b;
    pla_pkg::t_ctl                 r_ctl;

    logic [pla_pkg::WORD_BITS-1:0] n_a;
    logic [pla_pkg::WORD_BITS-1:0] n_b;
    pla_pkg::t_ctl                 n_ctl;
    logic [pla_pkg::WORD_BITS-1:0] rep;
    logic                          unary;
    logic                          arith;

    // Copy the low lane of the scalar into every lane.
    function automatic logic [pla_pkg::WORD_BITS-1:0] replicate(
        input logic [pla_pkg::WORD_BITS-1:0] v,
        input logic [2:0]                    lw
    );
        logic [pla_pkg::WORD_BITS-1:0] out;
        logic [5:0]                    m;
        m = pla_pkg::lane_mask6(lw);
        for (int k = 0; k < pla_pkg::WORD_BITS; k++) begin
            out[k] = v[6'(k) & m];
        end
        return out;
    endfunction

    // Decode the op class and pick the operands.
    always_comb begin
        unary = (i_cfg.op == pla_pkg::OP_NOT) || (i_cfg.op == pla_pkg::OP_NEG);
        arith = i_cfg.op inside {pla_pkg::OP_ADD, pla_pkg::OP_SUB,
                                 pla_pkg::OP_MUL, pla_pkg::OP_NEG};
        rep = replicate(i_cfg.scalar, i_cfg.lw);
        n_a = (!unary && i_cfg.side == pla_pkg::SIDE_LEFT) ? rep : i_left;
        n_b = (!unary && i_cfg.side == pla_pkg::SIDE_RIGHT) ? rep : i_right;
        n_ctl.op  = i_cfg.op;
        n_ctl.lw  = i_cfg.lw;
        n_ctl.err = arith && (i_cfg.lw < pla_pkg::LW_MIN || i_cfg.lw > pla_pkg::LW_MAX);
    end

    assign o_ready = !r_valid || i_ready_dn;

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_ctl <= n_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_ctl   = r_ctl;

endmodule

// ===== design/pla_compute.sv =====
`timescale 1ns / 1ps
// Second pipeline stage: bitwise and lane add, subtract, negate, plus all byte products.
// Depends on pla_pkg for codes, types and the lane top-bit mask.
module pla_compute (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_a,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_b,
    input  pla_pkg::t_ctl                  i_ctl,
    input  logic                           i_ready_dn,
    output logic                           o_valid,
    output logic [pla_pkg::WORD_BITS-1:0]  o_simple,
    output pla_pkg::t_prod                 o_prod,
    output pla_pkg::t_ctl                  o_ctl
);

    logic                          r_valid;
    logic [pla_pkg::WORD_BITS-1:0] r_simple;
    pla_pkg::t_prod                r_prod;
    pla_pkg::t_ctl                 r_ctl;

    logic [pla_pkg::WORD_BITS-1:0] n_simple;
    pla_pkg::t_prod                n_prod;
    logic [pla_pkg::WORD_BITS-1:0] h;
    logic [pla_pkg::WORD_BITS-1:0] sum;
    logic [pla_pkg::WORD_BITS-1:0] dif;
    logic [pla_pkg::WORD_BITS-1:0] neg;

    // Lane arithmetic: the top bit of each lane is handled apart so no carry
    // or borrow leaves its lane.
    always_comb begin
        h   = pla_pkg::hi_mask(i_ctl.lw);
        sum = ((i_a & ~h) + (i_b & ~h)) ^ ((i_a ^ i_b) & h);
        dif = ((i_a | h) - (i_b & ~h)) ^ ((i_a ^ ~i_b) & h);
        neg = (h - (i_b & ~h)) ^ (~i_b & h);
        case (i_ctl.op)
            pla_pkg::OP_AND: n_simple = i_a & i_b;
            pla_pkg::OP_OR:  n_simple = i_a | i_b;
            pla_pkg::OP_XOR: n_simple = i_a ^ i_b;
            pla_pkg::OP_NOT: n_simple = ~i_b;
            pla_pkg::OP_ADD: n_simple = sum;
            pla_pkg::OP_SUB: n_simple = dif;
            pla_pkg::OP_NEG: n_simple = neg;
            default:         n_simple = '0;
        endcase
    end

    // Every left byte times every right byte.
    always_comb begin
        for (int j = 0; j < pla_pkg::WORD_BYTES; j++) begin
            for (int i = 0; i < pla_pkg::WORD_BYTES; i++) begin
                n_prod[j * pla_pkg::WORD_BYTES + i] =
                    {8'd0, i_a[8 * i +: 8]} * {8'd0, i_b[8 * j +: 8]};
            end
        end
    end

    assign o_ready = !r_valid || i_ready_dn;

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_simple <= n_simple;
            r_prod   <= n_prod;
            r_ctl    <= i_ctl;
        end
    end

    assign o_valid  = r_valid;
    assign o_simple = r_simple;
    assign o_prod   = r_prod;
    assign o_ctl    = r_ctl;

endmodule

// ===== design/pla_reduce.sv =====
`timescale 1ns / 1ps
// Third and fourth pipeline stages: lane-segmented sum of the byte products and
// the final result select into the output register. Depends on pla_pkg.
module pla_reduce (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pla_pkg::WORD_BITS-1:0]  i_simple,
    input  pla_pkg::t_prod                 i_prod,
    input  pla_pkg::t_ctl                  i_ctl,
    input  logic                           i_ready_dn,
    output logic                           o_valid,
    output logic [pla_pkg::WORD_BITS-1:0]  o_result,
    output logic                           o_err
);

    typedef logic [pla_pkg::ROW_COUNT-1:0][pla_pkg::WORD_BITS-1:0]  t_rows;
    typedef logic [pla_pkg::PART_COUNT-1:0][pla_pkg::WORD_BITS-1:0] t_parts;

    logic                          r3_valid;
    t_parts                        r3_part;
    logic [pla_pkg::WORD_BITS-1:0] r3_simple;
    pla_pkg::t_ctl                 r3_ctl;
    logic                          r4_valid;
    logic [pla_pkg::WORD_BITS-1:0] r4_result;
    logic                          r4_err;

    t_rows                         rows;
    t_parts                        n_part;
    logic [pla_pkg::WORD_BITS-1:0] h2;
    logic [pla_pkg::WORD_BITS-1:0] h3;
    logic [pla_pkg::WORD_BITS-1:0] mul;
    logic [pla_pkg::WORD_BITS-1:0] n_result;
    logic                          ready3;

    // Lane width in bytes.
    function automatic logic [3:0] lane_chunks(input logic [2:0] lw);
        case (lw)
            3'd3:    return 4'd1;
            3'd4:    return 4'd2;
            3'd5:    return 4'd4;
            default: return 4'd8;
        endcase
    endfunction

    // Add lane by lane; carries stop at the top bit of each lane.
    function automatic logic [pla_pkg::WORD_BITS-1:0] seg_add(
        input logic [pla_pkg::WORD_BITS-1:0] x,
        input logic [pla_pkg::WORD_BITS-1:0] y,
        input logic [pla_pkg::WORD_BITS-1:0] h
    );
        logic [pla_pkg::WORD_BITS-1:0] low;
        low = (x & ~h) + (y & ~h);
        return low ^ ((x ^ y) & h);
    endfunction

    // One row of the product array: right byte j against left bytes of one
    // parity. Products of bytes in different lanes are dropped, and so are
    // bytes that land past the end of their lane. Products in one row never
    // overlap, so they merge by OR.
    function automatic logic [pla_pkg::WORD_BITS-1:0] build_row(
        input pla_pkg::t_prod prod,
        input logic [2:0]     j,
        input logic           q,
        input logic [2:0]     lw
    );
        logic [pla_pkg::WORD_BITS-1:0] row;
        logic [3:0]                    lc;
        logic [3:0]                    msk;
        logic [3:0]                    i4;
        logic [3:0]                    j4;
        logic [3:0]                    s;
        logic [3:0]                    sj;
        logic [3:0]                    pos;
        logic [3:0]                    p;
        logic [7:0]                    lo;
        logic [7:0]                    hi;
        logic [15:0]                   pv;
        row = '0;
        lc  = lane_chunks(lw);
        msk = lc - 4'd1;
        j4  = {1'b0, j};
        sj  = j4 & ~msk;
        for (int n = 0; n < pla_pkg::WORD_BYTES / 2; n++) begin
            i4  = 4'(2 * n) | {3'b000, q};
            s   = i4 & ~msk;
            pos = (i4 - s) + (j4 - s);
            p   = i4 + j4 - s;
            pv  = prod[{j, i4[2:0]}];
            if (s == sj && pos < lc) begin
                lo  = pv[7:0];
                hi  = ((pos + 4'd1) < lc) ? pv[15:8] : 8'd0;
                row = row | ({48'd0, hi, lo} << {p[2:0], 3'b000});
            end
        end
        return row;
    endfunction

    // Stage three: rows, then four partial sums of four rows each.
    always_comb begin
        h2 = pla_pkg::hi_mask(i_ctl.lw);
        for (int r = 0; r < pla_pkg::ROW_COUNT; r++) begin
            rows[r] = build_row(i_prod, 3'(r >> 1), 1'(r & 1), i_ctl.lw);
        end
        for (int g = 0; g < pla_pkg::PART_COUNT; g++) begin
            n_part[g] = seg_add(seg_add(rows[4 * g], rows[4 * g + 1], h2),
                                seg_add(rows[4 * g + 2], rows[4 * g + 3], h2), h2);
        end
    end

    // Stage four: final product sum and result select.
    always_comb begin
        h3  = pla_pkg::hi_mask(r3_ctl.lw);
        mul = seg_add(seg_add(r3_part[0], r3_part[1], h3),
                      seg_add(r3_part[2], r3_part[3], h3), h3);
        if (r3_ctl.err) begin
            n_result = '0;
        end else if (r3_ctl.op == pla_pkg::OP_MUL) begin
            n_result = mul;
        end else begin
            n_result = r3_simple;
        end
    end

    assign ready3  = !r4_valid || i_ready_dn;
    assign o_ready = !r3_valid || ready3;

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r3_valid <= i_valid;
            end
            if (ready3) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r3_part   <= n_part;
            r3_simple <= i_simple;
            r3_ctl    <= i_ctl;
        end
        if (ready3 && r3_valid) begin
            r4_result <= n_result;
            r4_err    <= r3_ctl.err;
        end
    end

    assign o_valid  = r4_valid;
    assign o_result = r4_result;
    assign o_err    = r4_err;

endmodule
